// File: rtl/core/dpb_pkg.sv
// dpb_pkg: shared types and constants for the depth pixel back-projection block
// pixel and point word layouts, configuration register codes, fixed-point widths
// no dependencies
package dpb_pkg;

  localparam int ImageDimDefault = 4096;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 32;

  localparam int RecipW  = 24;
  localparam int CenterW = 16;
  localparam int ZProdW  = 40;
  localparam int CoordW  = 32;
  localparam int MagW    = 16;
  localparam int TW      = MagW + CoordW;
  localparam int HalfW   = RecipW / 2;
  localparam int PartW   = TW + HalfW;
  localparam int SumW    = TW + RecipW + 1;
  localparam int RoundSh = 28;
  localparam int RW      = SumW - RoundSh;

  typedef enum logic [CfgIndexW-1:0] {
    REG_DEPTH_RECIP = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_INV_FOCAL_X = 3'd3,
    REG_INV_FOCAL_Y = 3'd4,
    REG_WIN_COLS    = 3'd5,
    REG_WIN_ROWS    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [15:0] depth_raw;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        point_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
  } point_t;

  typedef struct packed {
    logic [RecipW-1:0]  depth_recip;
    logic [CenterW-1:0] center_x;
    logic [CenterW-1:0] center_y;
    logic [RecipW-1:0]  inv_focal_x;
    logic [RecipW-1:0]  inv_focal_y;
    logic [31:0]        win_cols;
    logic [31:0]        win_rows;
  } cfg_t;

  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic [TW-1:0]     t_x;
    logic [TW-1:0]     t_y;
    logic [CoordW-1:0] z;
    logic [23:0]       colour;
  } front_t;

endpackage

// File: rtl/core/dpb_cfg.sv
// dpb_cfg: configuration register file
// depends on dpb_pkg
module dpb_cfg #(
  parameter int IMAGE_DIM = dpb_pkg::ImageDimDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpb_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [dpb_pkg::CfgDataW-1:0]  cfg_data,
  output dpb_pkg::cfg_t                  cfg
);

  localparam logic [15:0] WinEnd  = (IMAGE_DIM > 65535) ? 16'hFFFF : 16'(IMAGE_DIM);
  localparam logic [31:0] FullWin = {WinEnd, 16'h0000};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_recip <= 24'd16777;
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.inv_focal_x <= '0;
      cfg.inv_focal_y <= '0;
      cfg.win_cols    <= FullWin;
      cfg.win_rows    <= FullWin;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dpb_pkg::cfg_reg_e'(cfg_index))
        dpb_pkg::REG_DEPTH_RECIP: cfg.depth_recip <= cfg_data[dpb_pkg::RecipW-1:0];
        dpb_pkg::REG_CENTER_X:    cfg.center_x    <= cfg_data[dpb_pkg::CenterW-1:0];
        dpb_pkg::REG_CENTER_Y:    cfg.center_y    <= cfg_data[dpb_pkg::CenterW-1:0];
        dpb_pkg::REG_INV_FOCAL_X: cfg.inv_focal_x <= cfg_data[dpb_pkg::RecipW-1:0];
        dpb_pkg::REG_INV_FOCAL_Y: cfg.inv_focal_y <= cfg_data[dpb_pkg::RecipW-1:0];
        dpb_pkg::REG_WIN_COLS:    cfg.win_cols    <= cfg_data;
        dpb_pkg::REG_WIN_ROWS:    cfg.win_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/dpb_front.sv
// dpb_front: window and depth check, depth scaling and offset times depth
// three register stages; depends on dpb_pkg
module dpb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  dpb_pkg::pixel_t      pixel,
  input  dpb_pkg::cfg_t        cfg,
  output logic                 out_vld,
  output dpb_pkg::front_t      out
);

  logic                          pass;
  logic [15:0]                   p4_x, p4_y;
  logic                          n_x, n_y;
  logic [dpb_pkg::MagW-1:0]      m_x, m_y;
  logic [dpb_pkg::ZProdW:0]      zsum;

  logic                          s1_vld;
  logic                          s1_neg_x, s1_neg_y;
  logic [dpb_pkg::MagW-1:0]      s1_mag_x, s1_mag_y;
  logic [dpb_pkg::ZProdW-1:0]    s1_prod;
  logic [23:0]                   s1_colour;

  logic                          s2_vld;
  logic                          s2_neg_x, s2_neg_y;
  logic [dpb_pkg::MagW-1:0]      s2_mag_x, s2_mag_y;
  logic [dpb_pkg::CoordW-1:0]    s2_z;
  logic [23:0]                   s2_colour;

  always_comb begin
    pass = (pixel.depth_raw != 16'd0)
        && ({4'd0, pixel.pixel_col} >= cfg.win_cols[15:0])
        && ({4'd0, pixel.pixel_col} <  cfg.win_cols[31:16])
        && ({4'd0, pixel.pixel_row} >= cfg.win_rows[15:0])
        && ({4'd0, pixel.pixel_row} <  cfg.win_rows[31:16]);
    p4_x = {pixel.pixel_col, 4'd0};
    p4_y = {pixel.pixel_row, 4'd0};
    n_x  = p4_x < cfg.center_x;
    n_y  = p4_y < cfg.center_y;
    m_x  = n_x ? (cfg.center_x - p4_x) : (p4_x - cfg.center_x);
    m_y  = n_y ? (cfg.center_y - p4_y) : (p4_y - cfg.center_y);
    zsum = {1'b0, s1_prod} + (dpb_pkg::ZProdW+1)'(128);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      s1_vld  <= in_vld && pass;
      s2_vld  <= s1_vld;
      out_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_x  <= n_x;
      s1_neg_y  <= n_y;
      s1_mag_x  <= m_x;
      s1_mag_y  <= m_y;
      s1_prod   <= dpb_pkg::ZProdW'(pixel.depth_raw * cfg.depth_recip);
      s1_colour <= {pixel.blue_in, pixel.green_in, pixel.red_in};

      s2_neg_x  <= s1_neg_x;
      s2_neg_y  <= s1_neg_y;
      s2_mag_x  <= s1_mag_x;
      s2_mag_y  <= s1_mag_y;
      s2_z      <= zsum[dpb_pkg::CoordW+7:8];
      s2_colour <= s1_colour;

      out.neg_x  <= s2_neg_x;
      out.neg_y  <= s2_neg_y;
      out.t_x    <= dpb_pkg::TW'(s2_mag_x * s2_z);
      out.t_y    <= dpb_pkg::TW'(s2_mag_y * s2_z);
      out.z      <= s2_z;
      out.colour <= s2_colour;
    end
  end

endmodule

// File: rtl/core/dpb_scale.sv
// dpb_scale: focal scaling in two half products, rounding, saturation, output word
// three register stages; depends on dpb_pkg
module dpb_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  dpb_pkg::front_t      in,
  input  dpb_pkg::cfg_t        cfg,
  output logic                 point_valid,
  output dpb_pkg::point_t      point
);

  localparam int PW = dpb_pkg::PartW;
  localparam int HW = dpb_pkg::HalfW;
  localparam int SW = dpb_pkg::SumW;
  localparam int RW = dpb_pkg::RW;

  logic          s4_vld;
  logic          s4_neg_x, s4_neg_y;
  logic [PW-1:0] s4_lo_x, s4_hi_x, s4_lo_y, s4_hi_y;
  logic [31:0]   s4_z;
  logic [23:0]   s4_colour;

  logic          s5_vld;
  logic          s5_neg_x, s5_neg_y;
  logic [RW-1:0] s5_r_x, s5_r_y;
  logic [31:0]   s5_z;
  logic [23:0]   s5_colour;

  logic [SW-1:0] sum_x, sum_y;
  logic [31:0]   sat_x, sat_y;

  function automatic logic [31:0] dpb_sat(input logic neg, input logic [RW-1:0] r);
    logic [31:0] v;
    if (neg) begin
      v = (r > RW'(33'h080000000)) ? 32'h80000000 : r[31:0];
      v = 32'd0 - v;
    end else begin
      v = (r > RW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : r[31:0];
    end
    return v;
  endfunction

  always_comb begin
    sum_x = {1'b0, s4_hi_x, {HW{1'b0}}} + SW'(s4_lo_x) + (SW'(1) << 27);
    sum_y = {1'b0, s4_hi_y, {HW{1'b0}}} + SW'(s4_lo_y) + (SW'(1) << 27);
    sat_x = dpb_sat(s5_neg_x, s5_r_x);
    sat_y = dpb_sat(s5_neg_y, s5_r_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld      <= 1'b0;
      s5_vld      <= 1'b0;
      point_valid <= 1'b0;
    end else if (adv) begin
      s4_vld      <= in_vld;
      s5_vld      <= s4_vld;
      point_valid <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_neg_x  <= in.neg_x;
      s4_neg_y  <= in.neg_y;
      s4_lo_x   <= PW'(in.t_x * cfg.inv_focal_x[HW-1:0]);
      s4_hi_x   <= PW'(in.t_x * cfg.inv_focal_x[2*HW-1:HW]);
      s4_lo_y   <= PW'(in.t_y * cfg.inv_focal_y[HW-1:0]);
      s4_hi_y   <= PW'(in.t_y * cfg.inv_focal_y[2*HW-1:HW]);
      s4_z      <= in.z;
      s4_colour <= in.colour;

      s5_neg_x  <= s4_neg_x;
      s5_neg_y  <= s4_neg_y;
      s5_r_x    <= sum_x[SW-1:dpb_pkg::RoundSh];
      s5_r_y    <= sum_y[SW-1:dpb_pkg::RoundSh];
      s5_z      <= s4_z;
      s5_colour <= s4_colour;

      point.point_x   <= sat_x;
      point.point_y   <= sat_y;
      point.point_z   <= s5_z;
      point.blue_out  <= s5_colour[23:16];
      point.green_out <= s5_colour[15:8];
      point.red_out   <= s5_colour[7:0];
    end
  end

endmodule

// File: rtl/core/depth_pixel_backprojection.sv
// depth_pixel_backprojection: top level, pinhole back-projection of depth pixels
// depends on dpb_pkg, dpb_cfg, dpb_front, dpb_scale
//
//   channel   handshake                word
//   pixel     pixel_valid / pixel_stall  dpb_pkg::pixel_t
//   point     point_valid / point_stall  dpb_pkg::point_t
//   cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one pixel a cycle while point_stall does not hold the pipeline
// the register stages are the three multiplier stages, the two rounding adds and the saturation
// pixels with zero depth or outside the window drop out after the first stage
// the whole pipeline holds while the output word waits under point_stall
// rst is synchronous; it clears the valid bits and loads the register defaults
module depth_pixel_backprojection #(
  parameter int IMAGE_DIM = dpb_pkg::ImageDimDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  dpb_pkg::pixel_t                pixel,
  output logic                           point_valid,
  input  logic                           point_stall,
  output dpb_pkg::point_t                point,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpb_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [dpb_pkg::CfgDataW-1:0]  cfg_data
);

  dpb_pkg::cfg_t   cfg;
  dpb_pkg::front_t front;
  logic            front_vld;
  logic            adv;

  assign adv         = !(point_valid && point_stall);
  assign pixel_stall = !adv;

  dpb_cfg #(
    .IMAGE_DIM(IMAGE_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (pixel_valid),
    .pixel   (pixel),
    .cfg     (cfg),
    .out_vld (front_vld),
    .out     (front)
  );

  dpb_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_vld      (front_vld),
    .in          (front),
    .cfg         (cfg),
    .point_valid (point_valid),
    .point       (point)
  );

endmodule
